>>> rtl/fst_pkg.sv
// Shared types and constants for the format string tokenizer.
// No dependencies; imported by every module of the block.
package fst_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // result kinds
  localparam logic [3:0] K_LIT      = 4'd0;
  localparam logic [3:0] K_CONV     = 4'd1;
  localparam logic [3:0] K_WOVF     = 4'd2;
  localparam logic [3:0] K_POVF     = 4'd3;
  localparam logic [3:0] K_BADESC   = 4'd4;
  localparam logic [3:0] K_OCTOVF   = 4'd5;
  localparam logic [3:0] K_BADCONV  = 4'd6;
  localparam logic [3:0] K_OPENESC  = 4'd7;
  localparam logic [3:0] K_OPENSPEC = 4'd8;

  // one full result record
  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  data;
    logic [3:0]  conv;
    logic [4:0]  flags;
    logic [30:0] width;
    logic [31:0] prec;
  } rec_t;

  // queue word: results of one input byte; a second result is never a conversion
  typedef struct packed {
    rec_t       first;
    logic [3:0] kind2;
    logic [7:0] data2;
    logic       two;
  } entry_t;

endpackage

>>> rtl/fst_front.sv
// Front end: one byte per cycle while accept is high; builds the queue word.
// Depends on fst_pkg.
module fst_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     ch,
  input  logic           end_of_format,
  output logic           wr_en,
  output fst_pkg::entry_t wr_data
);
  import fst_pkg::*;

  localparam logic [3:0] PH_NORMAL    = 4'd0;
  localparam logic [3:0] PH_ESCAPE    = 4'd1;
  localparam logic [3:0] PH_OCT2      = 4'd2;
  localparam logic [3:0] PH_OCT3      = 4'd3;
  localparam logic [3:0] PH_FLAGS     = 4'd4;
  localparam logic [3:0] PH_WIDTH     = 4'd5;
  localparam logic [3:0] PH_WIDTH_SAT = 4'd6;
  localparam logic [3:0] PH_PREC      = 4'd7;
  localparam logic [3:0] PH_PREC_SAT  = 4'd8;
  localparam logic [3:0] PH_DRAIN     = 4'd9;

  localparam logic [34:0] SAT_MAX = 35'h07FFFFFFF;

  logic [3:0]  phase, phase_next;
  logic [7:0]  oct, oct_next;
  logic [4:0]  flags, flags_next;
  logic [30:0] wacc, wacc_next;
  logic [31:0] pacc, pacc_next;

  logic [1:0]  n;
  entry_t      e;
  logic        do_normal;
  logic        fin;
  logic        is_dig;
  logic        is_oct;
  logic [34:0] wt;
  logic [34:0] pt;
  logic [8:0]  ov;
  logic        conv_hit;
  logic [3:0]  conv_code;

  always_comb begin
    is_dig = (ch >= 8'h30) && (ch <= 8'h39);
    is_oct = (ch >= 8'h30) && (ch <= 8'h37);
    wt = ({4'b0, wacc} << 3) + ({4'b0, wacc} << 1) + {31'b0, ch[3:0]};
    pt = ({4'b0, pacc[30:0]} << 3) + ({4'b0, pacc[30:0]} << 1) + {31'b0, ch[3:0]};
    ov = {oct[5:0], ch[2:0]};
    conv_hit = 1'b1;
    unique case (ch)
      8'h62:   conv_code = 4'd0; // b
      8'h64:   conv_code = 4'd1; // d
      8'h69:   conv_code = 4'd2; // i
      8'h75:   conv_code = 4'd3; // u
      8'h6F:   conv_code = 4'd4; // o
      8'h78:   conv_code = 4'd5; // x
      8'h58:   conv_code = 4'd6; // X
      8'h63:   conv_code = 4'd7; // c
      8'h73:   conv_code = 4'd8; // s
      default: begin
        conv_code = 4'd0;
        conv_hit  = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_next = phase;
    oct_next   = oct;
    flags_next = flags;
    wacc_next  = wacc;
    pacc_next  = pacc;
    e          = '0;
    n          = 2'd0;
    do_normal  = 1'b0;
    fin        = 1'b0;

    if (phase == PH_DRAIN) begin
      if (end_of_format) begin
        phase_next = PH_NORMAL;
      end
    end else begin
      unique case (phase)
        PH_NORMAL: do_normal = 1'b1;
        PH_ESCAPE: begin
          phase_next   = PH_NORMAL;
          n            = 2'd1;
          e.first.kind = K_LIT;
          if (is_oct) begin
            oct_next   = {5'b0, ch[2:0]};
            phase_next = PH_OCT2;
            n          = 2'd0;
          end else begin
            unique case (ch)
              8'h5C:   e.first.data = 8'h5C;
              8'h61:   e.first.data = 8'd7;
              8'h62:   e.first.data = 8'd8;
              8'h66:   e.first.data = 8'd12;
              8'h6E:   e.first.data = 8'd10;
              8'h72:   e.first.data = 8'd13;
              8'h74:   e.first.data = 8'd9;
              8'h76:   e.first.data = 8'd11;
              default: begin
                e.first.kind = K_BADESC;
                e.first.data = ch;
                phase_next   = PH_DRAIN;
              end
            endcase
          end
        end
        PH_OCT2, PH_OCT3: begin
          if (is_oct) begin
            if (ov[8]) begin
              e.first.kind = K_OCTOVF;
              n            = 2'd1;
              oct_next     = 8'd0;
              phase_next   = PH_DRAIN;
            end else if (phase == PH_OCT2) begin
              oct_next   = ov[7:0];
              phase_next = PH_OCT3;
            end else begin
              e.first.kind = K_LIT;
              e.first.data = ov[7:0];
              n            = 2'd1;
              oct_next     = 8'd0;
              phase_next   = PH_NORMAL;
            end
          end else begin
            // digit run ended early: flush, then treat the byte as plain text
            e.first.kind = K_LIT;
            e.first.data = oct;
            n            = 2'd1;
            oct_next     = 8'd0;
            phase_next   = PH_NORMAL;
            do_normal    = 1'b1;
          end
        end
        PH_FLAGS: begin
          unique case (ch)
            8'h2D:   flags_next = flags | 5'b00001;
            8'h2B:   flags_next = flags | 5'b00010;
            8'h20:   flags_next = flags | 5'b00100;
            8'h23:   flags_next = flags | 5'b01000;
            8'h30:   flags_next = flags | 5'b10000;
            8'h2E: begin
              pacc_next  = 32'd0;
              phase_next = PH_PREC;
            end
            default: begin
              if (is_dig) begin
                phase_next = PH_WIDTH;
                if (wt > SAT_MAX) begin
                  wacc_next    = SAT_MAX[30:0];
                  e.first.kind = K_WOVF;
                  n            = 2'd1;
                  phase_next   = PH_WIDTH_SAT;
                end else begin
                  wacc_next = wt[30:0];
                end
              end else begin
                fin = 1'b1;
              end
            end
          endcase
        end
        PH_WIDTH, PH_WIDTH_SAT: begin
          if (is_dig) begin
            if (phase == PH_WIDTH) begin
              if (wt > SAT_MAX) begin
                wacc_next    = SAT_MAX[30:0];
                e.first.kind = K_WOVF;
                n            = 2'd1;
                phase_next   = PH_WIDTH_SAT;
              end else begin
                wacc_next = wt[30:0];
              end
            end
          end else if (ch == 8'h2E) begin
            pacc_next  = 32'd0;
            phase_next = PH_PREC;
          end else begin
            fin = 1'b1;
          end
        end
        PH_PREC, PH_PREC_SAT: begin
          if (is_dig) begin
            if (phase == PH_PREC) begin
              if (pt > SAT_MAX) begin
                pacc_next    = {1'b0, SAT_MAX[30:0]};
                e.first.kind = K_POVF;
                n            = 2'd1;
                phase_next   = PH_PREC_SAT;
              end else begin
                pacc_next = {1'b0, pt[30:0]};
              end
            end
          end else begin
            fin = 1'b1;
          end
        end
        default: begin
          phase_next = PH_NORMAL;
          do_normal  = 1'b1;
        end
      endcase

      if (do_normal) begin
        if (ch == 8'h5C) begin
          phase_next = PH_ESCAPE;
        end else if (ch == 8'h25) begin
          phase_next = PH_FLAGS;
        end else begin
          if (n == 2'd0) begin
            e.first.kind = K_LIT;
            e.first.data = ch;
          end else begin
            e.kind2 = K_LIT;
            e.data2 = ch;
          end
          n = n + 2'd1;
        end
      end

      if (fin) begin
        n = 2'd1;
        if (ch == 8'h25) begin
          e.first.kind = K_LIT;
          e.first.data = 8'h25;
          phase_next   = PH_NORMAL;
        end else if (conv_hit) begin
          e.first.kind  = K_CONV;
          e.first.conv  = conv_code;
          e.first.flags = flags;
          e.first.width = wacc;
          e.first.prec  = pacc;
          phase_next    = PH_NORMAL;
        end else begin
          e.first.kind = K_BADCONV;
          e.first.data = ch;
          phase_next   = PH_DRAIN;
        end
        flags_next = 5'd0;
        wacc_next  = 31'd0;
        pacc_next  = '1;
      end

      if (end_of_format) begin
        priority if (phase_next == PH_OCT2 || phase_next == PH_OCT3) begin
          if (n == 2'd0) begin
            e.first.kind = K_LIT;
            e.first.data = oct_next;
          end else begin
            e.kind2 = K_LIT;
            e.data2 = oct_next;
          end
          n = n + 2'd1;
        end else if (phase_next == PH_ESCAPE) begin
          if (n == 2'd0) begin
            e.first.kind = K_OPENESC;
          end else begin
            e.kind2 = K_OPENESC;
          end
          n = n + 2'd1;
        end else if (phase_next == PH_FLAGS || phase_next == PH_WIDTH ||
                     phase_next == PH_WIDTH_SAT || phase_next == PH_PREC ||
                     phase_next == PH_PREC_SAT) begin
          if (n == 2'd0) begin
            e.first.kind = K_OPENSPEC;
          end else begin
            e.kind2 = K_OPENSPEC;
          end
          n = n + 2'd1;
        end else begin
          n = n;
        end
      end
    end

    // end of string: everything back to its reset value
    if (end_of_format) begin
      phase_next = PH_NORMAL;
      oct_next   = 8'd0;
      flags_next = 5'd0;
      wacc_next  = 31'd0;
      pacc_next  = '1;
    end

    e.two = (n == 2'd2);
  end

  assign wr_en   = accept && (n != 2'd0);
  assign wr_data = e;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_NORMAL;
      oct   <= 8'd0;
      flags <= 5'd0;
      wacc  <= 31'd0;
      pacc  <= '1;
    end else if (accept) begin
      phase <= phase_next;
      oct   <= oct_next;
      flags <= flags_next;
      wacc  <= wacc_next;
      pacc  <= pacc_next;
    end
  end

endmodule

>>> rtl/fst_queue.sv
// Short word queue between the parser and the result side.
// Depends on fst_pkg (entry_t, QUEUE_DEPTH).
module fst_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  fst_pkg::entry_t wr_data,
  input  logic            rd_en,
  output fst_pkg::entry_t rd_data,
  output logic            q_full,
  output logic            q_empty
);
  import fst_pkg::*;

  entry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_wr;
  logic              do_rd;

  assign q_full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/fst_back.sv
// Result side: hands out the one or two results held in each queue word.
// Depends on fst_pkg.
module fst_back (
  input  logic                   clk,
  input  logic                   rst,
  input  fst_pkg::entry_t        head,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  logic                   pop,
  output logic                   empty,
  output logic [3:0]             kind,
  output logic [7:0]             out_byte,
  output logic [3:0]             conversion,
  output logic                   left_justify,
  output logic                   plus_sign,
  output logic                   space_sign,
  output logic                   alternate_form,
  output logic                   zero_pad,
  output logic [30:0]            min_width,
  output logic signed [31:0]     precision,
  output logic                   last_of_run
);
  import fst_pkg::*;

  logic sel;   // 1: second result of the head word is showing
  logic taken;

  assign empty = q_empty;
  assign taken = pop && !q_empty;
  assign q_pop = taken && (sel || !head.two);

  assign kind           = sel ? head.kind2 : head.first.kind;
  assign out_byte       = sel ? head.data2 : head.first.data;
  assign conversion     = sel ? 4'd0 : head.first.conv;
  assign left_justify   = !sel && head.first.flags[0];
  assign plus_sign      = !sel && head.first.flags[1];
  assign space_sign     = !sel && head.first.flags[2];
  assign alternate_form = !sel && head.first.flags[3];
  assign zero_pad       = !sel && head.first.flags[4];
  assign min_width      = sel ? 31'd0 : head.first.width;
  assign precision      = sel ? 32'sd0 : $signed(head.first.prec);
  assign last_of_run    = sel || !head.two;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (taken) begin
      sel <= !sel && head.two;
    end
  end

endmodule

>>> rtl/format_string_tokenizer_core.sv
// Format string tokenizer: top level.
// Instantiates fst_front, fst_queue and fst_back; depends on fst_pkg.
//
// Input side: one format byte a word, with end_of_format on the last byte.
// A word is taken on a rising edge with push high and full low.
// Result side: the oldest result sits on the ports while empty is low and
// is taken on a rising edge with pop high.
// Each byte is parsed in the cycle it is taken; its results (one or two)
// go into a four-word queue as one word (a byte with none writes none).
// A word written to an empty queue shows on the result ports next cycle.
// Input throughput is one byte per cycle while the queue has room. The
// result side gives one result per cycle while pop is high, so the two
// results of a byte go out one at a time; the queue absorbs such bursts.
// If pop stays low the queue fills and full rises; parsing state holds.
// Reset (rst, synchronous) empties the queue and returns the parser to
// plain text with no pending escape or specifier.
module format_string_tokenizer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         ch,
  input  logic               end_of_format,
  input  logic               push,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output logic [3:0]         kind,
  output logic [7:0]         out_byte,
  output logic [3:0]         conversion,
  output logic               left_justify,
  output logic               plus_sign,
  output logic               space_sign,
  output logic               alternate_form,
  output logic               zero_pad,
  output logic [30:0]        min_width,
  output logic signed [31:0] precision,
  output logic               last_of_run
);
  import fst_pkg::*;

  logic   accept;
  logic   wr_en;
  entry_t wr_data;
  entry_t head;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  fst_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .ch            (ch),
    .end_of_format (end_of_format),
    .wr_en         (wr_en),
    .wr_data       (wr_data)
  );

  fst_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .rd_en   (q_pop),
    .rd_data (head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  fst_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .kind           (kind),
    .out_byte       (out_byte),
    .conversion     (conversion),
    .left_justify   (left_justify),
    .plus_sign      (plus_sign),
    .space_sign     (space_sign),
    .alternate_form (alternate_form),
    .zero_pad       (zero_pad),
    .min_width      (min_width),
    .precision      (precision),
    .last_of_run    (last_of_run)
  );

endmodule

>>> sim/format_string_tokenizer_core_test.sv
// Self-checking testbench for format_string_tokenizer_core: directed strings, then random ones.
// Carries its own tokenizer model and compares every result word; needs fst_pkg and the RTL.
module format_string_tokenizer_core_test;
  import fst_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS_PER_MODE = 500;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_PERCENT   = 8'h25;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_SEVEN     = 8'h37;
  localparam logic [7:0] CH_NINE      = 8'h39;

  localparam logic [4:0] FL_LEFT  = 5'b00001;
  localparam logic [4:0] FL_PLUS  = 5'b00010;
  localparam logic [4:0] FL_SPACE = 5'b00100;
  localparam logic [4:0] FL_ALT   = 5'b01000;
  localparam logic [4:0] FL_ZERO  = 5'b10000;

  localparam logic [31:0] SAT_LIMIT = 32'h7FFF_FFFF;

  typedef enum logic [3:0] {
    ST_TEXT, ST_ESC, ST_OCT2, ST_OCT3, ST_FLAGS, ST_WIDTH, ST_WIDTH_SAT,
    ST_PREC, ST_PREC_SAT, ST_DROP
  } parse_state_t;

  typedef enum logic [3:0] {
    CV_B, CV_D, CV_I, CV_U, CV_O, CV_LX, CV_UX, CV_C, CV_S
  } conv_t;

  typedef struct {
    logic [3:0]  kind;
    logic [7:0]  data;
    logic [3:0]  conv;
    logic [4:0]  flags;
    logic [30:0] width;
    logic [31:0] prec;
    logic        last_tok;
  } token_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [7:0]        ch = 8'h00;
  logic              end_of_format = 1'b0;
  logic              push = 1'b0;
  logic              pop = 1'b0;
  logic              full;
  logic              empty;
  logic [3:0]        kind;
  logic [7:0]        out_byte;
  logic [3:0]        conversion;
  logic              left_justify;
  logic              plus_sign;
  logic              space_sign;
  logic              alternate_form;
  logic              zero_pad;
  logic [30:0]       min_width;
  logic signed [31:0] precision;
  logic              last_of_run;

  format_string_tokenizer_core dut (
    .clk(clk), .rst(rst), .ch(ch), .end_of_format(end_of_format),
    .push(push), .full(full), .empty(empty), .pop(pop),
    .kind(kind), .out_byte(out_byte), .conversion(conversion),
    .left_justify(left_justify), .plus_sign(plus_sign), .space_sign(space_sign),
    .alternate_form(alternate_form), .zero_pad(zero_pad),
    .min_width(min_width), .precision(precision), .last_of_run(last_of_run)
  );

  always #2 clk = ~clk;

  // tokenizer model state
  parse_state_t parse_st = ST_TEXT;
  logic [8:0]   oct_val = '0;
  logic [4:0]   spec_fl = '0;
  logic [31:0]  width_acc = '0;
  logic [31:0]  prec_acc = 32'hFFFF_FFFF;
  token_t       step_toks [0:1];
  int           step_n;
  token_t       pending_tokens [$];

  int errors = 0;
  int cycles = 0;
  int parsed_items = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic [7:0] fmt_q [$];

  task automatic clear_spec();
    spec_fl   = '0;
    width_acc = '0;
    prec_acc  = 32'hFFFF_FFFF;
  endtask

  task automatic reset_parser();
    parse_st = ST_TEXT;
    oct_val  = '0;
    clear_spec();
  endtask

  task automatic emit_token(input logic [3:0] k, input logic [7:0] b, input logic [3:0] cv);
    token_t t;
    if (step_n >= 2) return;
    t = '{kind: k, data: b, conv: 4'd0, flags: 5'd0, width: 31'd0, prec: 32'd0,
          last_tok: 1'b0};
    if (k == K_CONV) begin
      t.conv  = cv;
      t.flags = spec_fl;
      t.width = width_acc[30:0];
      t.prec  = prec_acc;
    end
    step_toks[step_n] = t;
    step_n++;
  endtask

  // one decimal digit into a saturating accumulator
  task automatic accum_digit(inout logic [31:0] v, input logic [7:0] c, output logic sat);
    logic [63:0] t;
    t = {33'd0, v[30:0]} * 64'd10 + {60'd0, c[3:0]};
    if (t > {32'd0, SAT_LIMIT}) begin
      v = SAT_LIMIT;
      sat = 1'b1;
    end else begin
      v = t[31:0];
      sat = 1'b0;
    end
  endtask

  task automatic finish_spec(input logic [7:0] c);
    logic       hit;
    logic [3:0] cv;
    hit = 1'b1;
    cv  = CV_B;
    case (c)
      "b": cv = CV_B;
      "d": cv = CV_D;
      "i": cv = CV_I;
      "u": cv = CV_U;
      "o": cv = CV_O;
      "x": cv = CV_LX;
      "X": cv = CV_UX;
      "c": cv = CV_C;
      "s": cv = CV_S;
      default: hit = 1'b0;
    endcase
    if (c == CH_PERCENT) begin
      emit_token(K_LIT, CH_PERCENT, 4'd0);
      clear_spec();
      parse_st = ST_TEXT;
    end else if (hit) begin
      emit_token(K_CONV, 8'd0, cv);
      clear_spec();
      parse_st = ST_TEXT;
    end else begin
      emit_token(K_BADCONV, c, 4'd0);
      clear_spec();
      parse_st = ST_DROP;
    end
  endtask

  // works out the results of one accepted byte and queues them
  task automatic tokenize_byte(input logic [7:0] c, input logic eof);
    logic        again;
    logic        sat;
    logic [11:0] ov;
    logic        is_dec;
    logic        is_oct;
    step_n = 0;
    is_dec = (c >= CH_ZERO) && (c <= CH_NINE);
    is_oct = (c >= CH_ZERO) && (c <= CH_SEVEN);
    if (parse_st == ST_DROP) begin
      if (eof) reset_parser();
      return;
    end
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (parse_st)
        ST_TEXT: begin
          if (c == CH_BACKSLASH) parse_st = ST_ESC;
          else if (c == CH_PERCENT) parse_st = ST_FLAGS;
          else emit_token(K_LIT, c, 4'd0);
        end
        ST_ESC: begin
          parse_st = ST_TEXT;
          if (is_oct) begin
            oct_val  = {6'd0, c[2:0]};
            parse_st = ST_OCT2;
          end else begin
            case (c)
              CH_BACKSLASH: emit_token(K_LIT, CH_BACKSLASH, 4'd0);
              "a": emit_token(K_LIT, 8'd7, 4'd0);
              "b": emit_token(K_LIT, 8'd8, 4'd0);
              "f": emit_token(K_LIT, 8'd12, 4'd0);
              "n": emit_token(K_LIT, 8'd10, 4'd0);
              "r": emit_token(K_LIT, 8'd13, 4'd0);
              "t": emit_token(K_LIT, 8'd9, 4'd0);
              "v": emit_token(K_LIT, 8'd11, 4'd0);
              default: begin
                emit_token(K_BADESC, c, 4'd0);
                parse_st = ST_DROP;
              end
            endcase
          end
        end
        ST_OCT2, ST_OCT3: begin
          if (is_oct) begin
            ov = {oct_val, 3'b000} + {9'd0, c[2:0]};
            if (ov > 12'd255) begin
              emit_token(K_OCTOVF, 8'd0, 4'd0);
              oct_val  = '0;
              parse_st = ST_DROP;
            end else if (parse_st == ST_OCT2) begin
              oct_val  = ov[8:0];
              parse_st = ST_OCT3;
            end else begin
              emit_token(K_LIT, ov[7:0], 4'd0);
              oct_val  = '0;
              parse_st = ST_TEXT;
            end
          end else begin
            // digits ended early: flush the value, then treat the byte as plain text
            emit_token(K_LIT, oct_val[7:0], 4'd0);
            oct_val  = '0;
            parse_st = ST_TEXT;
            again    = 1'b1;
          end
        end
        ST_FLAGS: begin
          if (c == CH_MINUS) spec_fl |= FL_LEFT;
          else if (c == CH_PLUS) spec_fl |= FL_PLUS;
          else if (c == CH_SPACE) spec_fl |= FL_SPACE;
          else if (c == CH_HASH) spec_fl |= FL_ALT;
          else if (c == CH_ZERO) spec_fl |= FL_ZERO;
          else if (is_dec) begin
            parse_st = ST_WIDTH;
            again    = 1'b1;
          end else if (c == CH_DOT) begin
            prec_acc = '0;
            parse_st = ST_PREC;
          end else finish_spec(c);
        end
        ST_WIDTH, ST_WIDTH_SAT: begin
          if (is_dec) begin
            if (parse_st == ST_WIDTH) begin
              accum_digit(width_acc, c, sat);
              if (sat) begin
                emit_token(K_WOVF, 8'd0, 4'd0);
                parse_st = ST_WIDTH_SAT;
              end
            end
          end else if (c == CH_DOT) begin
            prec_acc = '0;
            parse_st = ST_PREC;
          end else finish_spec(c);
        end
        ST_PREC, ST_PREC_SAT: begin
          if (is_dec) begin
            if (parse_st == ST_PREC) begin
              accum_digit(prec_acc, c, sat);
              if (sat) begin
                emit_token(K_POVF, 8'd0, 4'd0);
                parse_st = ST_PREC_SAT;
              end
            end
          end else finish_spec(c);
        end
        default: ;
      endcase
    end
    if (eof) begin
      case (parse_st)
        ST_OCT2, ST_OCT3: emit_token(K_LIT, oct_val[7:0], 4'd0);
        ST_ESC: emit_token(K_OPENESC, 8'd0, 4'd0);
        ST_FLAGS, ST_WIDTH, ST_WIDTH_SAT, ST_PREC, ST_PREC_SAT:
          emit_token(K_OPENSPEC, 8'd0, 4'd0);
        default: ;
      endcase
      reset_parser();
    end
    if (step_n > 0) step_toks[step_n - 1].last_tok = 1'b1;
    for (int i = 0; i < step_n; i++) pending_tokens.push_back(step_toks[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic check_token();
    token_t t;
    if (pending_tokens.size() == 0) begin
      $error("result word with nothing expected: kind %0d", kind);
      errors++;
    end else begin
      t = pending_tokens.pop_front();
      check_field("kind", 32'(t.kind), 32'(kind));
      check_field("out_byte", 32'(t.data), 32'(out_byte));
      check_field("conversion", 32'(t.conv), 32'(conversion));
      check_field("left_justify", 32'(t.flags[0]), 32'(left_justify));
      check_field("plus_sign", 32'(t.flags[1]), 32'(plus_sign));
      check_field("space_sign", 32'(t.flags[2]), 32'(space_sign));
      check_field("alternate_form", 32'(t.flags[3]), 32'(alternate_form));
      check_field("zero_pad", 32'(t.flags[4]), 32'(zero_pad));
      check_field("min_width", 32'(t.width), 32'(min_width));
      check_field("precision", t.prec, precision);
      check_field("last_of_run", 32'(t.last_tok), 32'(last_of_run));
    end
  endtask

  // result side: sample at the edge, then decide pop for the next one
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_token();
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL format_string_tokenizer_core");
      $finish;
    end
  end

  // push stays high between back-to-back words and drops while the sender idles
  task automatic send_byte(input logic [7:0] c, input logic eof);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    ch <= c;
    end_of_format <= eof;
    @(posedge clk);
    while (full) @(posedge clk);
    if (parse_st != ST_DROP) parsed_items++;
    tokenize_byte(c, eof);
  endtask

  task automatic send_string(input string s, input logic eof);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eof && (i == s.len() - 1));
  endtask

  task automatic send_fmt(input int n);
    for (int i = 0; i < n; i++) send_byte(fmt_q[i], i == n - 1);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_idling(input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
  endtask

  task automatic add_digits(input int n);
    repeat (n) fmt_q.push_back(CH_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic add_piece();
    string      esc_chars;
    string      flag_chars;
    string      conv_chars;
    logic [7:0] b;
    int         sel;
    int         r;
    int         nd;
    esc_chars  = "\\abfnrtv";
    flag_chars = "-+ #0";
    conv_chars = "bdiuoxXcs";
    sel = $urandom_range(99);
    if (sel < 35) begin
      b = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(8'h7E, 8'h20));
      if (b == CH_BACKSLASH || b == CH_PERCENT) b = "_";
      fmt_q.push_back(b);
    end else if (sel < 50) begin
      fmt_q.push_back(CH_BACKSLASH);
      fmt_q.push_back(esc_chars[$urandom_range(7)]);
    end else if (sel < 65) begin
      // mostly in range; a leading 4..7 with three digits overflows
      fmt_q.push_back(CH_BACKSLASH);
      nd = $urandom_range(3, 1);
      if ($urandom_range(99) < 85) fmt_q.push_back(CH_ZERO + 8'($urandom_range(3)));
      else fmt_q.push_back(CH_ZERO + 8'($urandom_range(7, 4)));
      repeat (nd - 1) fmt_q.push_back(CH_ZERO + 8'($urandom_range(7)));
    end else begin
      fmt_q.push_back(CH_PERCENT);
      repeat ($urandom_range(3)) fmt_q.push_back(flag_chars[$urandom_range(4)]);
      r = $urandom_range(99);
      if (r < 55) add_digits($urandom_range(3, 1));
      else if (r < 60) add_digits($urandom_range(12, 10));
      r = $urandom_range(99);
      if (r < 40) begin
        fmt_q.push_back(CH_DOT);
        add_digits($urandom_range(3));
      end else if (r < 45) begin
        fmt_q.push_back(CH_DOT);
        add_digits($urandom_range(12, 10));
      end
      r = $urandom_range(99);
      if (r < 88) fmt_q.push_back(conv_chars[$urandom_range(8)]);
      else if (r < 94) fmt_q.push_back(CH_PERCENT);
      else fmt_q.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic build_format();
    fmt_q.delete();
    repeat ($urandom_range(6, 1)) add_piece();
  endtask

  task automatic test_plain_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte("A", 1'b1);
    send_byte("z", 1'b1);
  endtask

  task automatic test_escapes();
    send_string("\\\\\\a\\b\\f\\n\\r\\t\\v", 1'b1);
    send_string("\\101\\0x\\18\\12", 1'b1);
    send_string("\\377", 1'b1);
    send_string("\\400zz", 1'b1);
    send_string("\\qabc", 1'b1);
    send_string("\\7%", 1'b1);
    send_string("\\", 1'b1);
  endtask

  task automatic test_specifiers();
    send_string("%-+ #0d", 1'b1);
    send_string("%b%d%i%u%o%x%X%c%s", 1'b1);
    send_string("%12.7x%.d%-07%", 1'b1);
    send_string("%2147483647d%2147483648d", 1'b1);
    send_string("%.21474836470s", 1'b1);
    send_string("%y%dz", 1'b1);
    send_string("%5", 1'b1);
    send_string("%.3", 1'b1);
    send_string("%", 1'b1);
  endtask

  task automatic test_random_strings(input int target);
    int goal;
    int form;
    int len;
    goal = parsed_items + target;
    while (parsed_items < goal) begin
      form = $urandom_range(99);
      build_format();
      if (form < 75) begin
        send_fmt(fmt_q.size());
      end else if (form < 90) begin
        send_fmt($urandom_range(fmt_q.size(), 1));
      end else begin
        len = $urandom_range(8, 1);
        for (int i = 0; i < len; i++)
          send_byte(8'($urandom_range(255)), ($urandom_range(3) == 0) || (i == len - 1));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    set_idling(7, 66);
    test_plain_bytes();
    test_escapes();
    test_specifiers();
    test_random_strings(RANDOM_ITEMS_PER_MODE);
    wait_drained();
    set_idling(66, 7);
    test_random_strings(RANDOM_ITEMS_PER_MODE);
    set_idling(0, 0);
    test_random_strings(RANDOM_ITEMS_PER_MODE);
    push <= 1'b0;
    for (int i = 0; i < 5000 && pending_tokens.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_tokens.size() != 0) begin
      $error("%0d expected results never arrived", pending_tokens.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS format_string_tokenizer_core");
    end else begin
      $display("FAIL format_string_tokenizer_core");
    end
    $finish;
  end

endmodule

>>> format_string_tokenizer_core.f
rtl/fst_pkg.sv
rtl/fst_front.sv
rtl/fst_queue.sv
rtl/fst_back.sv
rtl/format_string_tokenizer_core.sv
sim/format_string_tokenizer_core_test.sv
